@@ hdl/tpqc_pkg.sv @@
`timescale 1ns / 1ps

package tpqc_pkg;

  localparam int TICK_W     = 12;
  localparam int DIST_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DET_W = 38;
  localparam int SQ_W  = 36;
  localparam int LIN_W = 48;
  localparam int CON_W = 58;
  localparam int PRD_W = 30;
  localparam int ACC_W = 64;
  localparam int MB_W  = 17;
  localparam int REM_W = 66;
  localparam int DEN_W = 39;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR_TICKS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_DISTANCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_TICKS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_DISTANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_TICKS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_DISTANCE    = 3'd5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_UNFIT    = 2'd2
  } status_e;

  typedef enum logic {
    CMD_FIT     = 1'b0,
    CMD_MEASURE = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    STP_D0, STP_D1,
    STP_A0, STP_A1, STP_A2,
    STP_B0, STP_B1, STP_B2,
    STP_C0, STP_C1, STP_C2, STP_C3, STP_C4, STP_C5,
    STP_M0, STP_M1
  } step_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_MUL,
    BK_DIV_CHK,
    BK_DIV_SAT,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic              kind;
    logic [TICK_W-1:0] ticks;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [1:0]        status;
  } out_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [TICK_W-1:0] ticks;
  } q_entry_t;

  typedef struct packed {
    logic [TICK_W-1:0] x0;
    logic [DIST_W-1:0] y0;
    logic [TICK_W-1:0] x1;
    logic [DIST_W-1:0] y1;
    logic [TICK_W-1:0] x2;
    logic [DIST_W-1:0] y2;
  } cal_t;

endpackage

@@ hdl/tpqc_front.sv @@
`timescale 1ns / 1ps

module tpqc_front #(
  parameter int TICK_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  tpqc_pkg::in_t      in_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output tpqc_pkg::q_entry_t q_entry_o
);

  localparam logic [tpqc_pkg::TICK_W-1:0] TMASK =
    tpqc_pkg::TICK_W'((1 << TICK_BITS) - 1);

  tpqc_pkg::q_entry_t entry_q [2];
  tpqc_pkg::q_entry_t entry_in;
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         count_q;
  logic               push, pop;

  always_comb begin
    entry_in.cmd   = in_i.kind ? tpqc_pkg::CMD_MEASURE : tpqc_pkg::CMD_FIT;
    entry_in.ticks = in_i.ticks & TMASK;
  end

  assign busy      = (count_q == 2'd2);
  assign push      = start && !busy;
  assign q_valid_o = (count_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_entry_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= entry_in;
  end

endmodule

@@ hdl/tpqc_back.sv @@
`timescale 1ns / 1ps

module tpqc_back #(
  parameter int DIST_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  tpqc_pkg::q_entry_t q_entry_i,
  input  tpqc_pkg::cal_t     cal_i,
  output logic               done_o,
  output tpqc_pkg::out_t     res_o
);

  localparam int QB    = DIST_BITS + 1;
  localparam int DCW   = $clog2(QB);
  localparam int CNT_W = $clog2(tpqc_pkg::MB_W);
  localparam logic [tpqc_pkg::DIST_W-1:0] DMAX =
    tpqc_pkg::DIST_W'((1 << DIST_BITS) - 1);

  tpqc_pkg::back_state_e state_q, state_d;
  tpqc_pkg::step_e       step_q;
  tpqc_pkg::status_e     fit_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DCW-1:0]        dcnt_q;

  logic signed [tpqc_pkg::ACC_W-1:0] acc_q, a_q, t0_q;
  logic        [tpqc_pkg::MB_W-1:0]  b_q;
  logic signed [tpqc_pkg::PRD_W-1:0] p0_q, p1_q, p2_q;
  logic signed [tpqc_pkg::DET_W-1:0] det_q;
  logic signed [tpqc_pkg::SQ_W-1:0]  sq_q;
  logic signed [tpqc_pkg::LIN_W-1:0] lin_q;
  logic signed [tpqc_pkg::CON_W-1:0] con_q;
  logic        [tpqc_pkg::TICK_W-1:0] tk_q;
  logic        [tpqc_pkg::REM_W-1:0] rem_q, sub_q;
  logic        [QB-1:0]              quo_q;
  tpqc_pkg::out_t                    res_q;

  logic signed [tpqc_pkg::TICK_W:0]  d01, d02, d12;
  logic        [tpqc_pkg::TICK_W:0]  s01, s02, s12;
  logic signed [tpqc_pkg::ACC_W-1:0] op_a, addend, prod, nn;
  logic signed [tpqc_pkg::MB_W-1:0]  op_b;
  logic        [tpqc_pkg::DEN_W-1:0] dd;
  logic                              last_bit, mul_done, sat, ge;
  logic        [QB-1:0]              q_fin;
  logic        [tpqc_pkg::MB_W-1:0]  q_ext;

  always_comb begin
    d01 = $signed({1'b0, cal_i.x0}) - $signed({1'b0, cal_i.x1});
    d02 = $signed({1'b0, cal_i.x0}) - $signed({1'b0, cal_i.x2});
    d12 = $signed({1'b0, cal_i.x1}) - $signed({1'b0, cal_i.x2});
    s01 = {1'b0, cal_i.x0} + {1'b0, cal_i.x1};
    s02 = {1'b0, cal_i.x0} + {1'b0, cal_i.x2};
    s12 = {1'b0, cal_i.x1} + {1'b0, cal_i.x2};
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_q)
      tpqc_pkg::STP_D0: begin op_a = 64'(d01); op_b = 17'(d02); end
      tpqc_pkg::STP_D1: begin op_a = t0_q; op_b = 17'(d12); end
      tpqc_pkg::STP_A0: begin op_a = 64'(cal_i.y0); op_b = 17'(d12); end
      tpqc_pkg::STP_A1: begin op_a = 64'(cal_i.y1); op_b = 17'(d02); end
      tpqc_pkg::STP_A2: begin op_a = 64'(cal_i.y2); op_b = 17'(d01); end
      tpqc_pkg::STP_B0: begin op_a = 64'(p0_q); op_b = 17'(s12); end
      tpqc_pkg::STP_B1: begin op_a = 64'(p1_q); op_b = 17'(s02); end
      tpqc_pkg::STP_B2: begin op_a = 64'(p2_q); op_b = 17'(s01); end
      tpqc_pkg::STP_C0: begin op_a = 64'(p0_q); op_b = 17'(cal_i.x1); end
      tpqc_pkg::STP_C1: begin op_a = t0_q; op_b = 17'(cal_i.x2); end
      tpqc_pkg::STP_C2: begin op_a = 64'(p1_q); op_b = 17'(cal_i.x0); end
      tpqc_pkg::STP_C3: begin op_a = t0_q; op_b = 17'(cal_i.x2); end
      tpqc_pkg::STP_C4: begin op_a = 64'(p2_q); op_b = 17'(cal_i.x0); end
      tpqc_pkg::STP_C5: begin op_a = t0_q; op_b = 17'(cal_i.x1); end
      tpqc_pkg::STP_M0: begin op_a = 64'(sq_q); op_b = 17'(tk_q); end
      tpqc_pkg::STP_M1: begin op_a = t0_q + 64'(lin_q); op_b = 17'(tk_q); end
      default: ;
    endcase
  end

  // serial signed multiply, top bit of b has negative weight
  assign last_bit = (cnt_q == CNT_W'(tpqc_pkg::MB_W - 1));
  assign addend   = b_q[0] ? (last_bit ? -a_q : a_q) : '0;
  assign prod     = acc_q + addend;
  assign mul_done = (state_q == tpqc_pkg::BK_MUL) && last_bit;

  always_comb begin
    nn = det_q[tpqc_pkg::DET_W-1] ? -t0_q : t0_q;
    dd = det_q[tpqc_pkg::DET_W-1] ? -tpqc_pkg::DEN_W'(det_q) : tpqc_pkg::DEN_W'(det_q);
  end

  assign sat   = rem_q >= (sub_q << QB);
  assign ge    = rem_q >= sub_q;
  assign q_fin = {quo_q[QB-2:0], ge};
  assign q_ext = tpqc_pkg::MB_W'(q_fin);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpqc_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          if (q_entry_i.cmd == tpqc_pkg::CMD_FIT || fit_q == tpqc_pkg::ST_OK) begin
            state_d = tpqc_pkg::BK_LOAD;
          end else begin
            state_d = tpqc_pkg::BK_DONE;
          end
        end
      end
      tpqc_pkg::BK_LOAD: state_d = tpqc_pkg::BK_MUL;
      tpqc_pkg::BK_MUL: begin
        if (last_bit) begin
          if (step_q == tpqc_pkg::STP_C5) state_d = tpqc_pkg::BK_DONE;
          else if (step_q == tpqc_pkg::STP_M1) state_d = tpqc_pkg::BK_DIV_CHK;
          else state_d = tpqc_pkg::BK_LOAD;
        end
      end
      tpqc_pkg::BK_DIV_CHK: begin
        if (nn[tpqc_pkg::ACC_W-1]) state_d = tpqc_pkg::BK_DONE;
        else state_d = tpqc_pkg::BK_DIV_SAT;
      end
      tpqc_pkg::BK_DIV_SAT: begin
        if (sat) state_d = tpqc_pkg::BK_DONE;
        else state_d = tpqc_pkg::BK_DIV;
      end
      tpqc_pkg::BK_DIV: begin
        if (dcnt_q == '0) state_d = tpqc_pkg::BK_DONE;
      end
      tpqc_pkg::BK_DONE: state_d = tpqc_pkg::BK_IDLE;
      default: state_d = tpqc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready_o = (state_q == tpqc_pkg::BK_IDLE);
    done_o    = (state_q == tpqc_pkg::BK_DONE);
    res_o     = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpqc_pkg::BK_IDLE;
      fit_q   <= tpqc_pkg::ST_UNFIT;
    end else begin
      state_q <= state_d;
      if (mul_done && step_q == tpqc_pkg::STP_C5) begin
        fit_q <= (det_q == '0) ? tpqc_pkg::ST_SINGULAR : tpqc_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tpqc_pkg::BK_IDLE: begin
        tk_q   <= q_entry_i.ticks;
        step_q <= (q_entry_i.cmd == tpqc_pkg::CMD_FIT) ? tpqc_pkg::STP_D0
                                                       : tpqc_pkg::STP_M0;
        res_q.distance <= '0;
        res_q.status   <= fit_q;
      end
      tpqc_pkg::BK_LOAD: begin
        acc_q <= '0;
        a_q   <= op_a;
        b_q   <= op_b;
        cnt_q <= '0;
      end
      tpqc_pkg::BK_MUL: begin
        acc_q <= prod;
        a_q   <= a_q <<< 1;
        b_q   <= b_q >> 1;
        cnt_q <= cnt_q + CNT_W'(1);
        if (last_bit) begin
          step_q <= tpqc_pkg::step_e'(step_q + 4'd1);
          case (step_q)
            tpqc_pkg::STP_D0: t0_q  <= prod;
            tpqc_pkg::STP_D1: det_q <= prod[tpqc_pkg::DET_W-1:0];
            tpqc_pkg::STP_A0: begin
              p0_q <= prod[tpqc_pkg::PRD_W-1:0];
              sq_q <= prod[tpqc_pkg::SQ_W-1:0];
            end
            tpqc_pkg::STP_A1: begin
              p1_q <= prod[tpqc_pkg::PRD_W-1:0];
              sq_q <= sq_q - prod[tpqc_pkg::SQ_W-1:0];
            end
            tpqc_pkg::STP_A2: begin
              p2_q <= prod[tpqc_pkg::PRD_W-1:0];
              sq_q <= sq_q + prod[tpqc_pkg::SQ_W-1:0];
            end
            tpqc_pkg::STP_B0: lin_q <= -prod[tpqc_pkg::LIN_W-1:0];
            tpqc_pkg::STP_B1: lin_q <= lin_q + prod[tpqc_pkg::LIN_W-1:0];
            tpqc_pkg::STP_B2: lin_q <= lin_q - prod[tpqc_pkg::LIN_W-1:0];
            tpqc_pkg::STP_C0, tpqc_pkg::STP_C2, tpqc_pkg::STP_C4,
            tpqc_pkg::STP_M0: t0_q <= prod;
            tpqc_pkg::STP_C1: con_q <= prod[tpqc_pkg::CON_W-1:0];
            tpqc_pkg::STP_C3: con_q <= con_q - prod[tpqc_pkg::CON_W-1:0];
            tpqc_pkg::STP_C5: begin
              con_q          <= con_q + prod[tpqc_pkg::CON_W-1:0];
              res_q.distance <= '0;
              res_q.status   <= (det_q == '0) ? tpqc_pkg::ST_SINGULAR : tpqc_pkg::ST_OK;
            end
            tpqc_pkg::STP_M1: t0_q <= prod + 64'(con_q);
            default: ;
          endcase
        end
      end
      tpqc_pkg::BK_DIV_CHK: begin
        rem_q          <= {1'b0, nn, 1'b0} + tpqc_pkg::REM_W'(dd);
        sub_q          <= tpqc_pkg::REM_W'({dd, 1'b0});
        res_q.distance <= '0;
        res_q.status   <= tpqc_pkg::ST_OK;
      end
      tpqc_pkg::BK_DIV_SAT: begin
        sub_q          <= sub_q << (QB - 1);
        quo_q          <= '0;
        dcnt_q         <= DCW'(QB - 1);
        res_q.distance <= DMAX;
      end
      tpqc_pkg::BK_DIV: begin
        if (ge) rem_q <= rem_q - sub_q;
        sub_q  <= sub_q >> 1;
        quo_q  <= q_fin;
        dcnt_q <= dcnt_q - DCW'(1);
        res_q.distance <= (q_ext > tpqc_pkg::MB_W'(DMAX)) ? DMAX
                                                         : tpqc_pkg::DIST_W'(q_fin);
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/three_point_quadratic_calibration.sv @@
`timescale 1ns / 1ps
// Three-point quadratic range calibration.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// indexes 0..5 are near/middle/far ticks and distances, others are dropped.
// cfg_ready_o is always high. Write config only while the block is idle.
// Command channel: an item transfers when start is high and busy is low.
// kind 0 fits the quadratic from the calibration registers, kind 1 converts
// a tick count. Items go through a two-entry queue to the arithmetic engine.
// Each item gives one result on res_o, flagged by done_o for one cycle; the
// receiver cannot stall and must take it then.
// Products come from one shared shift-add multiplier and quotients from a
// one-bit-per-cycle divider. A fit takes 14 products; a measure takes two
// products and a division, which stops early when the value is negative
// (distance 0) or far above range (saturated); a measure with no valid fit
// skips the arithmetic. Items are processed one at a time; a queued item waits.
// After reset all calibration registers are zero and status reads "not
// fitted" until the first fit item.
module three_point_quadratic_calibration #(
  parameter int TICK_BITS = 12,
  parameter int DIST_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  tpqc_pkg::in_t                       in_i,
  output logic                                done_o,
  output tpqc_pkg::out_t                      res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tpqc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tpqc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam logic [tpqc_pkg::TICK_W-1:0] TMASK =
    tpqc_pkg::TICK_W'((1 << TICK_BITS) - 1);
  localparam logic [tpqc_pkg::DIST_W-1:0] DMASK =
    tpqc_pkg::DIST_W'((1 << DIST_BITS) - 1);

  tpqc_pkg::cal_t     cal_q, cal_m;
  tpqc_pkg::q_entry_t q_entry;
  logic               q_valid, q_ready, cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        tpqc_pkg::REG_NEAR_TICKS:      cal_q.x0 <= cfg_data_i[tpqc_pkg::TICK_W-1:0];
        tpqc_pkg::REG_NEAR_DISTANCE:   cal_q.y0 <= cfg_data_i;
        tpqc_pkg::REG_MIDDLE_TICKS:    cal_q.x1 <= cfg_data_i[tpqc_pkg::TICK_W-1:0];
        tpqc_pkg::REG_MIDDLE_DISTANCE: cal_q.y1 <= cfg_data_i;
        tpqc_pkg::REG_FAR_TICKS:       cal_q.x2 <= cfg_data_i[tpqc_pkg::TICK_W-1:0];
        tpqc_pkg::REG_FAR_DISTANCE:    cal_q.y2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cal_m.x0 = cal_q.x0 & TMASK;
    cal_m.x1 = cal_q.x1 & TMASK;
    cal_m.x2 = cal_q.x2 & TMASK;
    cal_m.y0 = cal_q.y0 & DMASK;
    cal_m.y1 = cal_q.y1 & DMASK;
    cal_m.y2 = cal_q.y2 & DMASK;
  end

  tpqc_front #(
    .TICK_BITS(TICK_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_entry_o (q_entry)
  );

  tpqc_back #(
    .DIST_BITS(DIST_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_entry_i (q_entry),
    .cal_i     (cal_m),
    .done_o    (done_o),
    .res_o     (res_o)
  );

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_bad_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != tpqc_pkg::ST_OK) |-> (res_o.distance == '0))
    else $error("nonzero distance without a valid fit");

  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !q_ready) |=> q_valid)
    else $error("queued item lost while engine busy");

  a_pop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready) |=> !q_ready)
    else $error("engine still idle in the cycle after a queue pop");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import tpqc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_i = '0;
  logic done_o;
  out_t res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  three_point_quadratic_calibration dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("tb_top NOT OK");
    $finish;
  end

  typedef struct {
    bit                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]        data;
    cmd_e               kind;
    logic [11:0]        ticks;
    bit                 fixed;
    logic [15:0]        exp_dist;
    status_e            st;
  } row_t;

  // calibration mirror and fit
  longint cal_x [3];
  longint cal_y [3];
  longint fit_det, fit_sq, fit_lin, fit_con;
  status_e fit_st = ST_UNFIT;

  out_t pending_results[$];
  int errors = 0;
  int n_items = 0;

  function automatic void cal_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
    case (idx)
      REG_NEAR_TICKS:      cal_x[0] = d[11:0];
      REG_NEAR_DISTANCE:   cal_y[0] = d;
      REG_MIDDLE_TICKS:    cal_x[1] = d[11:0];
      REG_MIDDLE_DISTANCE: cal_y[1] = d;
      REG_FAR_TICKS:       cal_x[2] = d[11:0];
      REG_FAR_DISTANCE:    cal_y[2] = d;
      default: ;
    endcase
  endfunction

  function automatic out_t calibrate(cmd_e k, logic [11:0] t);
    longint d01, d02, d12, tt, num, den, q;
    out_t r;
    r.distance = '0;
    if (k == CMD_FIT) begin
      d01 = cal_x[0] - cal_x[1];
      d02 = cal_x[0] - cal_x[2];
      d12 = cal_x[1] - cal_x[2];
      fit_det = d01 * d02 * d12;
      fit_sq = cal_y[0] * d12 - cal_y[1] * d02 + cal_y[2] * d01;
      fit_lin = -cal_y[0] * (cal_x[1] + cal_x[2]) * d12
                + cal_y[1] * (cal_x[0] + cal_x[2]) * d02
                - cal_y[2] * (cal_x[0] + cal_x[1]) * d01;
      fit_con = cal_y[0] * cal_x[1] * cal_x[2] * d12
                - cal_y[1] * cal_x[0] * cal_x[2] * d02
                + cal_y[2] * cal_x[0] * cal_x[1] * d01;
      fit_st = (fit_det == 0) ? ST_SINGULAR : ST_OK;
    end else if (fit_st == ST_OK) begin
      tt = t;
      num = fit_sq * tt * tt + fit_lin * tt + fit_con;
      den = fit_det;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      if (num >= 0) begin
        q = (2 * num + den) / (2 * den);
        r.distance = (q > 65535) ? 16'hffff : q[15:0];
      end
    end
    r.status = fit_st;
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_t e;
    if (done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: dist %0d status %0d",
                 $time, res_o.distance, res_o.status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (res_o.distance !== e.distance)
          begin
          $display("%0t: distance exp %0d got %0d", $time, e.distance, res_o.distance);
          errors++;
        end
        if (res_o.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, res_o.status);
          errors++;
        end
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cal_write(idx, d);
    @(negedge clk_i);
  endtask

  task automatic send_cmd(cmd_e k, logic [11:0] t, bit fixed = 0,
                          logic [15:0] ed = '0, status_e es = ST_OK);
    out_t e;
    cfg_valid_i <= 1'b0;
    in_i <= '{kind: k, ticks: t};
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    e = calibrate(k, t);
    if (fixed) e = '{distance: ed, status: es};
    pending_results.push_back(e);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      cfg_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  function automatic logic [11:0] pick_ticks();
    int p;
    p = $urandom_range(0, 9);
    if (p < 3) return 12'($urandom_range(0, 4095));
    if (p < 4) return ($urandom_range(0, 1) != 0) ? 12'h000 : 12'hfff;
    p = int'(cal_x[$urandom_range(0, 2)]) + $signed($urandom_range(0, 8)) - 4;
    if (p < 0) p = 0;
    if (p > 4095) p = 4095;
    return 12'(p);
  endfunction

  row_t dir_rows[$];

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] i, logic [15:0] d);
    dir_rows.push_back('{is_cfg: 1, idx: i, data: d, kind: CMD_FIT, ticks: 0,
                         fixed: 0, exp_dist: 0, st: ST_OK});
  endfunction

  function automatic void add_cmd(cmd_e k, logic [11:0] t, bit f = 0,
                                  logic [15:0] d = 0, status_e s = ST_OK);
    dir_rows.push_back('{is_cfg: 0, idx: 0, data: 0, kind: k, ticks: t,
                         fixed: f, exp_dist: d, st: s});
  endfunction

  initial begin
    int j;
    logic [15:0] v;
    for (int i = 0; i < 3; i++) begin
      cal_x[i] = 0;
      cal_y[i] = 0;
    end

    add_cmd(CMD_MEASURE, 12'h000, 1, 0, ST_UNFIT);
    add_cmd(CMD_MEASURE, 12'hfff, 1, 0, ST_UNFIT);
    add_cmd(CMD_FIT, 12'hfff, 1, 0, ST_SINGULAR);
    add_cmd(CMD_MEASURE, 12'd100, 1, 0, ST_SINGULAR);
    add_cfg(REG_NEAR_TICKS, 16'd100);
    add_cfg(REG_NEAR_DISTANCE, 16'd1000);
    add_cfg(REG_MIDDLE_TICKS, 16'd2000);
    add_cfg(REG_MIDDLE_DISTANCE, 16'd30000);
    add_cfg(REG_FAR_TICKS, 16'hffff);
    add_cfg(REG_FAR_DISTANCE, 16'hffff);
    add_cfg(3'd6, 16'hffff);
    add_cfg(3'd7, 16'h5a5a);
    add_cmd(CMD_FIT, 12'd0, 1, 0, ST_OK);
    add_cmd(CMD_MEASURE, 12'd100, 1, 16'd1000, ST_OK);
    add_cmd(CMD_MEASURE, 12'd2000, 1, 16'd30000, ST_OK);
    add_cmd(CMD_MEASURE, 12'hfff, 1, 16'hffff, ST_OK);
    add_cmd(CMD_MEASURE, 12'h000);
    add_cmd(CMD_MEASURE, 12'h555);
    // steep parabola: saturates high far out, touches zero at the vertex
    add_cfg(REG_NEAR_TICKS, 16'd0);
    add_cfg(REG_NEAR_DISTANCE, 16'hffff);
    add_cfg(REG_MIDDLE_TICKS, 16'd1);
    add_cfg(REG_MIDDLE_DISTANCE, 16'd0);
    add_cfg(REG_FAR_TICKS, 16'd2);
    add_cmd(CMD_MEASURE, 12'hfff, 1, 16'hffff, ST_OK);
    add_cmd(CMD_FIT, 12'd0, 1, 0, ST_OK);
    add_cmd(CMD_MEASURE, 12'd1, 1, 0, ST_OK);
    add_cmd(CMD_MEASURE, 12'hfff, 1, 16'hffff, ST_OK);
    add_cfg(REG_NEAR_TICKS, 16'd0);
    add_cfg(REG_NEAR_DISTANCE, 16'hffff);
    add_cfg(REG_MIDDLE_TICKS, 16'd2048);
    add_cfg(REG_MIDDLE_DISTANCE, 16'd0);
    add_cfg(REG_FAR_TICKS, 16'd4095);
    add_cfg(REG_FAR_DISTANCE, 16'hffff);
    add_cmd(CMD_FIT, 12'd0);
    add_cmd(CMD_MEASURE, 12'd2047);
    add_cmd(CMD_MEASURE, 12'd2048, 1, 0, ST_OK);
    add_cmd(CMD_MEASURE, 12'd1000);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        if (i == 0 || !dir_rows[i-1].is_cfg) drain();
        cfg_write(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_cmd(dir_rows[i].kind, dir_rows[i].ticks, dir_rows[i].fixed,
                 dir_rows[i].exp_dist, dir_rows[i].st);
        pause(gap_len());
      end
    end

    while (n_items < 640) begin
      drain();
      j = $urandom_range(0, 9);
      for (int r = 0; r < 6; r++) begin
        if (j == 0) v = (r[0]) ? 16'hffff : ($urandom_range(0, 1) ? 16'hffff : 16'h0);
        else v = 16'($urandom);
        cfg_write(CFG_IDX_W'(r), v);
      end
      if (j == 1) cfg_write(REG_FAR_TICKS, 16'(cal_x[$urandom_range(0, 1)]));
      if (j == 2) cfg_write(CFG_IDX_W'($urandom_range(6, 7)), 16'($urandom));
      if ($urandom_range(0, 5) == 0) send_cmd(CMD_MEASURE, pick_ticks());
      send_cmd(CMD_FIT, 12'($urandom));
      if (j == 3) begin
        drain();
        cfg_write(REG_MIDDLE_DISTANCE, 16'($urandom));
      end
      for (int m = $urandom_range(5, 30); m > 0; m--) begin
        pause(gap_len());
        if ($urandom_range(0, 19) == 0) send_cmd(CMD_FIT, 12'($urandom));
        else send_cmd(CMD_MEASURE, pick_ticks());
      end
    end

    drain();
    repeat (400) @(posedge clk_i);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
